FILE: hw/rtl/fcmsl_pkg.sv
// Shared types and constants for the FAT cluster link map sector locator.
// Holds request, status and register codes, the micro-op set and the microcode table.
// No dependencies.
package fcmsl_pkg;

  localparam int unsigned UPC_W = 5;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_LOCATE = 2'd1;
  localparam logic [1:0] REQ_SETPOS = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INT  = 2'd1;
  localparam logic [1:0] ST_DISK = 2'd2;

  localparam logic [1:0] REG_SPC   = 2'd0;
  localparam logic [1:0] REG_DAS   = 2'd1;
  localparam logic [1:0] REG_FEC   = 2'd2;
  localparam logic [1:0] REG_FIRST = 2'd3;

  localparam int unsigned BLOCK_SHIFT   = 9;
  localparam logic [31:0] BLOCK_BYTES   = 32'd512;
  localparam logic [31:0] CLUSTER_FIRST = 32'd2;
  localparam logic [31:0] CLUSTER_EOC   = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_FIRST,
    OP_INIT_WALK,
    OP_RD_LEN,
    OP_ADVANCE,
    OP_RD_START,
    OP_ADD_START,
    OP_SET_CUR,
    OP_MUL,
    OP_BASE,
    OP_DONE_OK,
    OP_DONE_INT,
    OP_DONE_DISK
  } uop_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_SPC_ZERO,
    C_OFFS_NZ,
    C_POS_ZERO,
    C_IDX_OOR,
    C_LEN_ZERO,
    C_CL_LT,
    C_IDX1_OOR,
    C_CL_LT2,
    C_CL_ALL1,
    C_C_OOR,
    C_BASE_ZERO
  } ucond_t;

  typedef struct packed {
    uop_t             op;
    ucond_t           cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic spc_zero;
    logic offs_nz;
    logic pos_zero;
    logic idx_oor;
    logic len_zero;
    logic cl_lt;
    logic idx1_oor;
    logic cl_lt2;
    logic cl_all1;
    logic c_oor;
    logic base_zero;
  } seq_flags_t;

  typedef struct packed {
    logic busy;
    uop_t op;
  } seq_ctl_t;

  localparam logic [UPC_W-1:0] UA_WALK     = 5'd4;
  localparam logic [UPC_W-1:0] UA_FOUND    = 5'd8;
  localparam logic [UPC_W-1:0] UA_CHKCL    = 5'd10;
  localparam logic [UPC_W-1:0] UA_CALC     = 5'd13;
  localparam logic [UPC_W-1:0] UA_ERR_INT  = 5'd17;
  localparam logic [UPC_W-1:0] UA_ERR_DISK = 5'd18;
  localparam logic [UPC_W-1:0] UA_NEXT     = 5'd0;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      5'd0:    w = '{OP_NOP,        C_SPC_ZERO,  UA_ERR_INT};
      5'd1:    w = '{OP_NOP,        C_OFFS_NZ,   UA_CALC};
      5'd2:    w = '{OP_LOAD_FIRST, C_POS_ZERO,  UA_CHKCL};
      5'd3:    w = '{OP_INIT_WALK,  C_NONE,      UA_NEXT};
      5'd4:    w = '{OP_RD_LEN,     C_IDX_OOR,   UA_ERR_INT};
      5'd5:    w = '{OP_NOP,        C_LEN_ZERO,  UA_ERR_INT};
      5'd6:    w = '{OP_NOP,        C_CL_LT,     UA_FOUND};
      5'd7:    w = '{OP_ADVANCE,    C_ALWAYS,    UA_WALK};
      5'd8:    w = '{OP_RD_START,   C_IDX1_OOR,  UA_ERR_INT};
      5'd9:    w = '{OP_ADD_START,  C_NONE,      UA_NEXT};
      5'd10:   w = '{OP_NOP,        C_CL_LT2,    UA_ERR_INT};
      5'd11:   w = '{OP_NOP,        C_CL_ALL1,   UA_ERR_DISK};
      5'd12:   w = '{OP_SET_CUR,    C_NONE,      UA_NEXT};
      5'd13:   w = '{OP_MUL,        C_C_OOR,     UA_ERR_INT};
      5'd14:   w = '{OP_BASE,       C_NONE,      UA_NEXT};
      5'd15:   w = '{OP_NOP,        C_BASE_ZERO, UA_ERR_INT};
      5'd16:   w = '{OP_DONE_OK,    C_NONE,      UA_NEXT};
      5'd17:   w = '{OP_DONE_INT,   C_NONE,      UA_NEXT};
      5'd18:   w = '{OP_DONE_DISK,  C_NONE,      UA_NEXT};
      default: w = '{OP_DONE_INT,   C_NONE,      UA_NEXT};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/fcmsl_seq.sv
// Microcode sequencer for the sector locator: step counter, control table and jumps.
// Depends on fcmsl_pkg.
module fcmsl_seq
  import fcmsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       hold,
  input  seq_flags_t flags,
  output seq_ctl_t   ctl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;
  uword_t           uw;
  logic             taken;
  logic             is_done;

  assign uw      = ucode_rom(upc_r);
  assign is_done = (uw.op == OP_DONE_OK) || (uw.op == OP_DONE_INT) ||
                   (uw.op == OP_DONE_DISK);

  always_comb begin
    unique case (uw.cond)
      C_NONE:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_SPC_ZERO:  taken = flags.spc_zero;
      C_OFFS_NZ:   taken = flags.offs_nz;
      C_POS_ZERO:  taken = flags.pos_zero;
      C_IDX_OOR:   taken = flags.idx_oor;
      C_LEN_ZERO:  taken = flags.len_zero;
      C_CL_LT:     taken = flags.cl_lt;
      C_IDX1_OOR:  taken = flags.idx1_oor;
      C_CL_LT2:    taken = flags.cl_lt2;
      C_CL_ALL1:   taken = flags.cl_all1;
      C_C_OOR:     taken = flags.c_oor;
      C_BASE_ZERO: taken = flags.base_zero;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = '0;
      end
    end else if (!hold) begin
      if (is_done) begin
        busy_nxt = 1'b0;
      end else if (taken) begin
        upc_nxt = uw.target;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign ctl.busy = busy_r;
  assign ctl.op   = busy_r ? uw.op : OP_NOP;

endmodule

FILE: hw/rtl/fat_cluster_map_sector_locator_top.sv
// Top level of the FAT cluster link map sector locator: datapath, map memory and handshakes.
// Depends on fcmsl_pkg and fcmsl_seq.
//
// Each input word carries a request: load a map word, locate the next 512-byte block, or set
// the byte position. Every request returns exactly one result word with a status and a
// sector address. The configuration channel writes the four registers by index and should
// only be used while no request is in flight.
// Load, set-position and unused requests answer in the cycle after they are accepted.
// A locate request runs a microcode program, one step per cycle unless the result word is held
// by a receiver stall, on a single datapath with one read port into the map memory. One request
// is in work at a time.
// A new request can be accepted in the same cycle that the previous result word is taken.
// When the receiver stalls, the result word holds and the input stalls with it.
// Synchronous reset restores the register defaults and clears position, current cluster
// and both channels; the map contents stay undefined until loaded.
module fat_cluster_map_sector_locator_top
  import fcmsl_pkg::*;
#(
  parameter int unsigned MAP_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_map_index,
  input  logic [31:0] in_map_word,
  input  logic [31:0] in_new_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_sector_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(MAP_WORDS);
  localparam int unsigned IW = $clog2(MAP_WORDS + 2);
  localparam logic [IW-1:0] MAP_LIMIT = IW'(MAP_WORDS);
  localparam logic [AW+5:0] MAP_LIMIT_W = (AW + 6)'(MAP_WORDS);

  logic [15:0]   spc_r, spc_nxt;
  logic [31:0]   das_r, das_nxt;
  logic [31:0]   fec_r, fec_nxt;
  logic [31:0]   fcl_r, fcl_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   cl_r, cl_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   base_r, base_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_sector_r, out_sector_nxt;

  logic [31:0]   map_mem [MAP_WORDS];
  logic [31:0]   rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW+5:0] wr_idx;

  seq_flags_t    flags;
  seq_ctl_t      ctl;
  logic          hold;
  logic          in_acc;
  logic          out_acc;
  logic          op_go;
  logic [31:0]   blk;
  logic [15:0]   spc_m1;
  logic [15:0]   offs;
  logic [3:0]    sh;
  logic [31:0]   cl_init;
  logic [IW-1:0] idx1;
  logic [31:0]   c_val;
  logic [47:0]   mul_full;

  assign blk     = pos_r >> BLOCK_SHIFT;
  assign spc_m1  = spc_r - 16'd1;
  assign offs    = blk[15:0] & spc_m1;
  assign idx1    = idx_r + 1'b1;
  assign c_val   = cur_r - CLUSTER_FIRST;
  assign mul_full = spc_r * c_val;

  always_comb begin
    sh = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (spc_r[i]) begin
        sh = 4'(i);
      end
    end
  end

  assign cl_init = blk >> sh;

  assign flags.spc_zero  = (spc_r == 16'd0);
  assign flags.offs_nz   = (offs != 16'd0);
  assign flags.pos_zero  = (pos_r == 32'd0);
  assign flags.idx_oor   = (idx_r >= MAP_LIMIT);
  assign flags.len_zero  = (rdata_r == 32'd0);
  assign flags.cl_lt     = (cl_r < rdata_r);
  assign flags.idx1_oor  = (idx1 >= MAP_LIMIT);
  assign flags.cl_lt2    = (cl_r < CLUSTER_FIRST);
  assign flags.cl_all1   = (cl_r == CLUSTER_EOC);
  assign flags.c_oor     = (c_val >= (fec_r - CLUSTER_FIRST));
  assign flags.base_zero = (base_r == 32'd0);

  assign in_stall  = ctl.busy | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid_r & ~out_stall;
  assign hold      = out_valid_r & out_stall;
  assign op_go     = ctl.busy & ~hold;
  assign cfg_ready = ~ctl.busy;

  fcmsl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_req_type == REQ_LOCATE)),
    .hold  (hold),
    .flags (flags),
    .ctl   (ctl)
  );

  assign wr_idx = {{AW{1'b0}}, in_map_index};
  assign wr_en  = in_acc && (in_req_type == REQ_LOAD) && (wr_idx < MAP_LIMIT_W);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    if (op_go && (ctl.op == OP_RD_LEN) && !flags.idx_oor) begin
      rd_en = 1'b1;
    end else if (op_go && (ctl.op == OP_RD_START) && !flags.idx1_oor) begin
      rd_en   = 1'b1;
      rd_addr = idx1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_idx[AW-1:0]] <= in_map_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= map_mem[rd_addr];
    end
  end

  always_comb begin
    spc_nxt        = spc_r;
    das_nxt        = das_r;
    fec_nxt        = fec_r;
    fcl_nxt        = fcl_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    cl_nxt         = cl_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    base_nxt       = base_r;
    out_valid_nxt  = out_valid_r & ~out_acc;
    out_status_nxt = out_status_r;
    out_sector_nxt = out_sector_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPC:   spc_nxt = cfg_data[15:0];
        REG_DAS:   das_nxt = cfg_data;
        REG_FEC:   fec_nxt = cfg_data;
        REG_FIRST: fcl_nxt = cfg_data;
        default:   spc_nxt = spc_r;
      endcase
    end

    if (in_acc) begin
      priority case (in_req_type)
        REQ_LOAD: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_sector_nxt = 32'd0;
        end
        REQ_LOCATE: begin
          out_valid_nxt = out_valid_r & ~out_acc;
        end
        REQ_SETPOS: begin
          pos_nxt        = in_new_position;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_sector_nxt = 32'd0;
        end
        default: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INT;
          out_sector_nxt = 32'd0;
        end
      endcase
    end

    if (op_go) begin
      unique case (ctl.op)
        OP_LOAD_FIRST: cl_nxt = fcl_r;
        OP_INIT_WALK: begin
          cl_nxt  = cl_init;
          idx_nxt = '0;
        end
        OP_ADVANCE: begin
          cl_nxt  = cl_r - rdata_r;
          idx_nxt = idx_r + IW'(2);
        end
        OP_ADD_START:  cl_nxt = cl_r + rdata_r;
        OP_SET_CUR:    cur_nxt = cl_r;
        OP_MUL:        prod_nxt = mul_full[31:0];
        OP_BASE:       base_nxt = das_r + prod_r;
        OP_DONE_OK: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_sector_nxt = base_r + {16'd0, offs};
          pos_nxt        = pos_r + BLOCK_BYTES;
        end
        OP_DONE_INT: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INT;
          out_sector_nxt = 32'd0;
        end
        OP_DONE_DISK: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DISK;
          out_sector_nxt = 32'd0;
        end
        default: cl_nxt = cl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= 16'd1;
      das_r       <= 32'd0;
      fec_r       <= 32'd0;
      fcl_r       <= 32'd0;
      pos_r       <= 32'd0;
      cur_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      spc_r       <= spc_nxt;
      das_r       <= das_nxt;
      fec_r       <= fec_nxt;
      fcl_r       <= fcl_nxt;
      pos_r       <= pos_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cl_r         <= cl_nxt;
    idx_r        <= idx_nxt;
    prod_r       <= prod_nxt;
    base_r       <= base_nxt;
    out_status_r <= out_status_nxt;
    out_sector_r <= out_sector_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_sector_address = out_sector_r;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat_cluster_map_sector_locator_top: directed and random requests,
// a tracker class that predicts each result word in order, and random idling on the input and result channels.
// Depends on fcmsl_pkg and the locator RTL.
module tb_top;
  import fcmsl_pkg::*;

  localparam int unsigned MAP_DEPTH    = 64;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CALM_ITEMS   = 300;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  index;
    logic [31:0] word;
    logic [31:0] position;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sector;
  } sector_result_t;

  class sector_tracker;
    logic [15:0]    spc;
    logic [31:0]    das;
    logic [31:0]    fec;
    logic [31:0]    first;
    logic [31:0]    position;
    logic [31:0]    cluster;
    logic [31:0]    map_mem [MAP_DEPTH];
    bit             map_written [MAP_DEPTH];
    sector_result_t pending_results [$];
    int             mismatches;

    function new();
      spc = 16'd1;
      das = '0;
      fec = '0;
      first = '0;
      position = '0;
      cluster = '0;
      mismatches = 0;
      foreach (map_mem[i]) begin
        map_mem[i] = '0;
        map_written[i] = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_SPC:   spc = data[15:0];
        REG_DAS:   das = data;
        REG_FEC:   fec = data;
        REG_FIRST: first = data;
      endcase
    endfunction

    // Walks the fragment list for the cluster that holds the current position.
    // Flags any read of a map word that was never loaded.
    function logic [1:0] walk_map(output logic [31:0] clst, output bit unsafe);
      logic [31:0] cl;
      logic [31:0] sz;
      int i;
      unsafe = 1'b0;
      clst = '0;
      cl = position >> BLOCK_SHIFT;
      sz = {16'd0, spc};
      while (sz[0] == 1'b0) begin
        cl = cl >> 1;
        sz = sz >> 1;
      end
      i = 0;
      forever begin
        if (i >= MAP_DEPTH) return ST_INT;
        if (!map_written[i]) unsafe = 1'b1;
        if (map_mem[i] == 0) return ST_INT;
        if (cl < map_mem[i]) break;
        cl = cl - map_mem[i];
        i += 2;
      end
      if (i + 1 >= MAP_DEPTH) return ST_INT;
      if (!map_written[i + 1]) unsafe = 1'b1;
      clst = cl + map_mem[i + 1];
      return ST_OK;
    endfunction

    function bit locate_is_safe();
      logic [31:0] blk;
      logic [31:0] clst;
      logic [1:0]  st;
      bit          unsafe;
      if (spc == 0 || position == 0) return 1'b1;
      blk = position >> BLOCK_SHIFT;
      if ((blk & ({16'd0, spc} - 1)) != 0) return 1'b1;
      st = walk_map(clst, unsafe);
      return !unsafe;
    endfunction

    function logic [1:0] locate_block(output logic [31:0] sector);
      logic [31:0] spc32;
      logic [31:0] offs;
      logic [31:0] clst;
      logic [31:0] c;
      logic [31:0] base;
      logic [1:0]  st;
      bit          unsafe;
      sector = '0;
      spc32 = {16'd0, spc};
      if (spc32 == 0) return ST_INT;
      offs = (position >> BLOCK_SHIFT) & (spc32 - 1);
      if (offs == 0) begin
        if (position == 0) begin
          clst = first;
        end else begin
          st = walk_map(clst, unsafe);
          if (st != ST_OK) return st;
        end
        if (clst < CLUSTER_FIRST) return ST_INT;
        if (clst == CLUSTER_EOC) return ST_DISK;
        cluster = clst;
      end
      c = cluster - CLUSTER_FIRST;
      if (c >= fec - CLUSTER_FIRST) return ST_INT;
      base = das + spc32 * c;
      if (base == 0) return ST_INT;
      sector = base + offs;
      position = position + BLOCK_BYTES;
      return ST_OK;
    endfunction

    function void note_request(request_t rq);
      sector_result_t r;
      logic [31:0]    sector;
      r.status = ST_OK;
      r.sector = '0;
      case (rq.req)
        REQ_LOAD: begin
          map_mem[rq.index] = rq.word;
          map_written[rq.index] = 1'b1;
        end
        REQ_LOCATE: begin
          r.status = locate_block(sector);
          r.sector = sector;
        end
        REQ_SETPOS: position = rq.position;
        default: r.status = ST_INT;
      endcase
      pending_results.push_back(r);
    endfunction

    task check_result(logic [1:0] status, logic [31:0] sector);
      sector_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with nothing pending: status %0d sector %h",
                         status, sector));
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status)
        report($sformatf("status got %0d expected %0d", status, e.status));
      if (sector !== e.sector)
        report($sformatf("sector_address got %h expected %h", sector, e.sector));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [5:0]  in_map_index = '0;
  logic [31:0] in_map_word = '0;
  logic [31:0] in_new_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_sector_address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sector_tracker tracker;
  bit            calm = 1'b0;
  int unsigned   items_sent = 0;
  int unsigned   calm_from = 32'hFFFF_FFFF;
  int unsigned   cycle_count = 0;

  fat_cluster_map_sector_locator_top #(
    .MAP_WORDS(MAP_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_map_index      (in_map_index),
    .in_map_word       (in_map_word),
    .in_new_position   (in_new_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_sector_address(out_sector_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_status, out_sector_address);
  end

  function automatic request_t scrambled_request(logic [1:0] req);
    request_t rq;
    rq.req = req;
    rq.index = 6'($urandom);
    rq.word = $urandom;
    rq.position = $urandom;
    return rq;
  endfunction

  function automatic logic [31:0] start_cluster();
    case ($urandom_range(15))
      0: return 32'd0;
      1: return 32'd1;
      2: return CLUSTER_EOC - $urandom_range(0, 3);
      3: return $urandom;
      default: return $urandom_range(2, 4000);
    endcase
  endfunction

  task automatic send(request_t rq);
    // A locate that would read a map word never loaded becomes a load instead.
    if (rq.req == REQ_LOCATE && !tracker.locate_is_safe()) begin
      rq.req = REQ_LOAD;
      rq.word = $urandom_range(1, 8);
    end
    calm = (items_sent >= calm_from) && (items_sent < calm_from + CALM_ITEMS);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq.req;
    in_map_index <= rq.index;
    in_map_word <= rq.word;
    in_new_position <= rq.position;
    do @(posedge clk); while (in_stall);
    tracker.note_request(rq);
    items_sent++;
  endtask

  task automatic load_word(int unsigned idx, logic [31:0] w);
    request_t rq;
    rq = scrambled_request(REQ_LOAD);
    rq.index = 6'(idx);
    rq.word = w;
    send(rq);
  endtask

  task automatic set_position(logic [31:0] p);
    request_t rq;
    rq = scrambled_request(REQ_SETPOS);
    rq.position = p;
    send(rq);
  endtask

  task automatic locate_next();
    send(scrambled_request(REQ_LOCATE));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
  endtask

  task automatic configure(logic [15:0] spc, logic [31:0] das, logic [31:0] fec,
                           logic [31:0] first);
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SPC, {16'($urandom), spc});
    write_reg(REG_DAS, das);
    write_reg(REG_FEC, fec);
    write_reg(REG_FIRST, first);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_configure();
    logic [15:0] spc;
    logic [31:0] das;
    logic [31:0] fec;
    logic [31:0] first;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) spc = 16'd0;
    else if (pick < 7) spc = 16'($urandom_range(1, 65535));
    else if (pick < 14) spc = 16'h8000;
    else if (pick < 20) spc = 16'd1;
    else spc = 16'd1 << $urandom_range(0, 15);
    case ($urandom_range(9))
      0: das = 32'd0;
      1: das = 32'hFFFF_FFFF;
      default: das = $urandom;
    endcase
    case ($urandom_range(11))
      0: fec = 32'd0;
      1: fec = 32'hFFFF_FFFF;
      2: fec = $urandom_range(0, 3000);
      default: fec = $urandom_range(32'h0001_0000, 32'hFFFF_FFF0);
    endcase
    case ($urandom_range(11))
      0: first = 32'd0;
      1: first = 32'd1;
      2: first = CLUSTER_EOC;
      3: first = $urandom;
      default: first = $urandom_range(2, 4000);
    endcase
    configure(spc, das, fec, first);
  endtask

  task automatic fragment_run();
    int unsigned frags;
    int unsigned total;
    int unsigned len;
    int unsigned span;
    logic [31:0] p;
    frags = $urandom_range(1, 6);
    total = 0;
    for (int k = 0; k < frags; k++) begin
      len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 8);
      total = (len < 64 && total < 64) ? total + len : 64;
      load_word(2 * k, len);
      load_word(2 * k + 1, start_cluster());
    end
    load_word(2 * frags, 32'd0);
    span = (total > 40) ? 40 : total + 1;
    p = $urandom_range(0, span) * {16'd0, tracker.spc};
    p = p << BLOCK_SHIFT;
    if ($urandom_range(4) == 0 && tracker.spc > 1)
      p = p + (32'($urandom_range(0, tracker.spc - 1)) << BLOCK_SHIFT);
    set_position(p);
    repeat ($urandom_range(3, 30)) locate_next();
  endtask

  task automatic full_map_run();
    int unsigned total;
    int unsigned len;
    logic [31:0] p;
    total = 0;
    for (int i = 0; i < MAP_DEPTH; i += 2) begin
      len = $urandom_range(1, 2);
      total += len;
      load_word(i, len);
      load_word(i + 1, start_cluster());
    end
    repeat ($urandom_range(2, 5)) begin
      p = $urandom_range(0, total + 4) * {16'd0, tracker.spc};
      set_position(p << BLOCK_SHIFT);
      repeat ($urandom_range(1, 4)) locate_next();
    end
  endtask

  task automatic noise_run();
    request_t rq;
    repeat ($urandom_range(3, 12)) begin
      rq = scrambled_request(2'($urandom_range(0, 3)));
      if (rq.req == REQ_LOAD && $urandom_range(3) == 0) rq.word = 32'd0;
      send(rq);
    end
  endtask

  task automatic jump_run();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(3) != 0) p[BLOCK_SHIFT-1:0] = '0;
    set_position(p);
    repeat ($urandom_range(1, 6)) locate_next();
  endtask

  initial begin
    int unsigned random_start;
    int unsigned next_phase;
    int unsigned pick;
    request_t    rq;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(16'd4, 32'h0000_1000, 32'h0001_0000, 32'd5);
    load_word(0, 32'd2);
    load_word(1, 32'd100);
    load_word(2, 32'd3);
    load_word(3, 32'hFFFF_FFFE);
    load_word(4, 32'd0);
    locate_next();
    locate_next();
    // Cluster lands out of the FAT range, then on the end-of-chain marker.
    set_position(32'd4096);
    locate_next();
    set_position(32'd6144);
    locate_next();
    // Past the last fragment: end of table.
    set_position(32'd10240);
    locate_next();
    set_position(32'd2048);
    locate_next();
    locate_next();
    rq = scrambled_request(REQ_UNUSED);
    send(rq);
    // Position that is not a multiple of 512.
    set_position(32'h0000_0A05);
    locate_next();
    set_position(32'hFFFF_FE00);
    locate_next();
    load_word(MAP_DEPTH - 1, 32'hFFFF_FFFF);
    // Start cluster of zero gives a cluster below two.
    load_word(1, 32'd0);
    set_position(32'd2048);
    locate_next();

    configure(16'd0, $urandom, 32'hFFFF_FFFF, 32'd7);
    locate_next();
    configure(16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CLUSTER_EOC);
    set_position(32'd0);
    locate_next();
    configure(16'd1, 32'd0, 32'd0, 32'd1);
    set_position(32'd0);
    locate_next();

    random_start = items_sent;
    calm_from = items_sent + 600;
    random_configure();
    next_phase = items_sent + PHASE_ITEMS;
    full_map_run();
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (items_sent >= next_phase) begin
        random_configure();
        next_phase = items_sent + PHASE_ITEMS;
      end
      pick = $urandom_range(99);
      if (pick < 60) fragment_run();
      else if (pick < 64) full_map_run();
      else if (pick < 84) noise_run();
      else jump_run();
    end

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fcmsl_pkg.sv
hw/rtl/fcmsl_seq.sv
hw/rtl/fat_cluster_map_sector_locator_top.sv
verif/tb_top.sv
